[rtl/assert_macros.svh]
// Assertion macros shared by the branch prediction buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BPB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define BPB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[rtl/bpb_pkg.sv]
// Types and constants of the branch prediction buffer.
package bpb_pkg;

   localparam int BPB_SETS       = 64;
   localparam int BPB_WAY_COUNT  = 2;
   localparam int BPB_CTR_LEVELS = 2;
   localparam int BPB_USE_LEVELS = 2;

   localparam int BPB_ADDR_W = 32;
   localparam int BPB_SET_W  = (BPB_SETS > 1) ? $clog2(BPB_SETS) : 1;
   localparam int BPB_WAY_W  = (BPB_WAY_COUNT > 1) ? $clog2(BPB_WAY_COUNT) : 1;
   localparam int BPB_CNT_W  = $clog2(BPB_CTR_LEVELS);
   localparam int BPB_USE_W  = $clog2(BPB_USE_LEVELS);

   localparam int BPB_USAGE_MAX   = BPB_USE_LEVELS - 1;
   localparam int BPB_WEAK_STATE  = BPB_CTR_LEVELS / 2 - 1;
   localparam int BPB_COUNTER_MAX = BPB_CTR_LEVELS - 1;
   localparam int BPB_PRED_THRESH = BPB_CTR_LEVELS / 2;

   typedef struct packed {
      logic [BPB_ADDR_W-1:0] tag;
      logic [BPB_CNT_W-1:0]  counter;
      logic [BPB_USE_W-1:0]  usage;
   } way_entry_type;

   typedef way_entry_type [BPB_WAY_COUNT-1:0] set_row_type;

   typedef struct packed {
      logic [BPB_ADDR_W-1:0] branch_addr;
      logic                  taken;
   } req_payload_type;

   typedef struct packed {
      logic        hit;
      logic        predicted_taken;
      logic        prediction_correct;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] correct_total;
      logic [31:0] incorrect_total;
   } rsp_payload_type;

   typedef struct packed {
      logic hit;
      logic predicted_taken;
      logic prediction_correct;
   } lookup_status_type;

endpackage

[rtl/branch_prediction_buffer_core.sv]
// Top level of the set-associative branch prediction buffer.
//
// Each request carries a resolved branch address and its outcome. The block
// takes a request in every cycle (busy is never raised) and returns exactly
// one result per request, marked by rsp_valid for one cycle; the receiver
// cannot stall it. The set's row is read from the on-chip set memory at the
// edge that accepts the request; in the following cycle the ways are
// compared, the prediction scored and a victim picked on a miss, and at the
// end of that cycle the row is written back while the result register
// captures the outcome and the running totals. The result is then driven
// on the ports from the result register. A request to the set written in
// the same cycle as its read sees the new row through a bypass register.
// Rows carry a valid bit each, cleared at reset, so the store reads as all
// zero straight after reset and no clearing pass is needed. With the enable
// written low by csr_write_data the block updates nothing and returns an
// all-zero result. Change the enable only while no request is in flight.
module branch_prediction_buffer_core
   import bpb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   output rsp_payload_type rsp_data,
   input  logic            csr_write_enable,
   input  logic            csr_write_data
);

`include "assert_macros.svh"

   // Configuration: predictor enable, set to one by reset.
   logic enable_ff;

   // Read stage.
   logic                 req_accept;
   logic [BPB_SET_W-1:0] req_set;
   logic                 s1_valid_ff;
   logic                 s1_en_ff;
   logic [BPB_SET_W-1:0] s1_set_ff;
   req_payload_type      s1_req_ff;
   set_row_type          rd_row_ff;

   // Set memory, one row per set, with a valid bit per row.
   set_row_type          row_mem [BPB_SETS];
   logic [BPB_SETS-1:0]  row_valid_ff;

   // Bypass of the row written at the same edge as the following read.
   logic                 byp_valid_ff;
   logic [BPB_SET_W-1:0] byp_set_ff;
   set_row_type          byp_row_ff;

   // Update stage.
   set_row_type          row_cur;
   set_row_type          row_new;
   lookup_status_type    status;
   logic                 wr_en;

   logic [31:0] hit_cnt_ff,       hit_cnt_in;
   logic [31:0] miss_cnt_ff,      miss_cnt_in;
   logic [31:0] correct_cnt_ff,   correct_cnt_in;
   logic [31:0] incorrect_cnt_ff, incorrect_cnt_in;
   logic [31:0] lookup_total;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   assign busy       = 1'b0;
   assign req_accept = start && !busy;
   assign req_set    = BPB_SET_W'(req_data.branch_addr % BPB_ADDR_W'(BPB_SETS));

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         enable_ff <= csr_write_data;
      end
   end

   // Capture the request and its enable; drop the valid when nothing comes.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
         s1_set_ff <= req_set;
         s1_en_ff  <= enable_ff;
      end
   end

   // Memory read and write ports.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_row_ff <= row_mem[req_set];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[s1_set_ff] <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[s1_set_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else begin
         byp_valid_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         byp_set_ff <= s1_set_ff;
         byp_row_ff <= row_new;
      end
   end

   // Pick the freshest copy of the row: bypass, memory, or reset zeros.
   always_comb begin
      if (byp_valid_ff && (byp_set_ff == s1_set_ff)) begin
         row_cur = byp_row_ff;
      end else if (row_valid_ff[s1_set_ff]) begin
         row_cur = rd_row_ff;
      end else begin
         row_cur = '0;
      end
   end

   bpb_set_update u_set_update (
      .row_cur     (row_cur),
      .branch_addr (s1_req_ff.branch_addr),
      .taken       (s1_req_ff.taken),
      .row_new     (row_new),
      .status      (status)
   );

   assign wr_en = s1_valid_ff && s1_en_ff;

   // Advance the totals only for enabled requests; they wrap at 2^32.
   always_comb begin
      hit_cnt_in       = hit_cnt_ff;
      miss_cnt_in      = miss_cnt_ff;
      correct_cnt_in   = correct_cnt_ff;
      incorrect_cnt_in = incorrect_cnt_ff;
      if (wr_en) begin
         if (status.hit) begin
            hit_cnt_in = hit_cnt_ff + 32'd1;
            if (status.prediction_correct) begin
               correct_cnt_in = correct_cnt_ff + 32'd1;
            end else begin
               incorrect_cnt_in = incorrect_cnt_ff + 32'd1;
            end
         end else begin
            miss_cnt_in = miss_cnt_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff       <= '0;
         miss_cnt_ff      <= '0;
         correct_cnt_ff   <= '0;
         incorrect_cnt_ff <= '0;
      end else begin
         hit_cnt_ff       <= hit_cnt_in;
         miss_cnt_ff      <= miss_cnt_in;
         correct_cnt_ff   <= correct_cnt_in;
         incorrect_cnt_ff <= incorrect_cnt_in;
      end
   end

   assign lookup_total = hit_cnt_ff + miss_cnt_ff;

   // A disabled request reports all zeros, the totals included.
   always_comb begin
      rsp_data_in = '0;
      if (s1_en_ff) begin
         rsp_data_in.hit                = status.hit;
         rsp_data_in.predicted_taken    = status.predicted_taken;
         rsp_data_in.prediction_correct = status.prediction_correct;
         rsp_data_in.hit_total          = hit_cnt_in;
         rsp_data_in.miss_total         = miss_cnt_in;
         rsp_data_in.correct_total      = correct_cnt_in;
         rsp_data_in.incorrect_total    = incorrect_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every accepted request yields its result through the result register.
   `BPB_ASSERT(a_rsp_latency, req_accept |-> ##2 rsp_valid, "result missing after request")
   // Correct and incorrect predictions together account for every hit.
   `BPB_ASSERT(a_score_balance, correct_cnt_ff + incorrect_cnt_ff == hit_cnt_ff, "scores lost")
   // An enabled request moves exactly one of hit and miss totals by one.
   `BPB_ASSERT(a_total_step, wr_en |=> lookup_total == $past(lookup_total) + 32'd1, "totals stuck")
   // A disabled request returns an all-zero result.
   `BPB_ASSERT(a_disabled_zero, s1_valid_ff && !s1_en_ff |=> rsp_data == '0, "nonzero result")
   // No result straight after reset.
   `BPB_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result strobe after reset")

endmodule

[rtl/bpb_set_update.sv]
// Lookup, scoring and replacement for one set of the prediction buffer.
module bpb_set_update
   import bpb_pkg::*;
(
   input  set_row_type           row_cur,
   input  logic [BPB_ADDR_W-1:0] branch_addr,
   input  logic                  taken,
   output set_row_type           row_new,
   output lookup_status_type     status
);

   logic                 found;
   logic [BPB_WAY_W-1:0] hit_way;
   logic [BPB_WAY_W-1:0] victim_way;
   logic [BPB_WAY_W-1:0] touched_way;
   logic [BPB_CNT_W-1:0] hit_counter;
   logic                 pred;

   // Last matching way wins; last way below full usage is the victim.
   always_comb begin
      found      = 1'b0;
      hit_way    = '0;
      victim_way = '0;
      for (int w = 0; w < BPB_WAY_COUNT; w++) begin
         if (row_cur[w].tag == branch_addr) begin
            found   = 1'b1;
            hit_way = BPB_WAY_W'(w);
         end
         if (row_cur[w].usage < BPB_USE_W'(BPB_USAGE_MAX)) begin
            victim_way = BPB_WAY_W'(w);
         end
      end
   end

   assign touched_way = found ? hit_way : victim_way;
   assign hit_counter = row_cur[hit_way].counter;
   assign pred        = found && (hit_counter >= BPB_CNT_W'(BPB_PRED_THRESH));

   always_comb begin
      row_new = row_cur;
      for (int w = 0; w < BPB_WAY_COUNT; w++) begin
         // Age every way, then mark the touched one as most recent.
         if (row_cur[w].usage != '0) begin
            row_new[w].usage = row_cur[w].usage - BPB_USE_W'(1);
         end
         if (BPB_WAY_W'(w) == touched_way) begin
            row_new[w].usage = BPB_USE_W'(BPB_USAGE_MAX);
            if (found) begin
               if (taken && (row_cur[w].counter < BPB_CNT_W'(BPB_COUNTER_MAX))) begin
                  row_new[w].counter = row_cur[w].counter + BPB_CNT_W'(1);
               end else if (!taken && (row_cur[w].counter != '0)) begin
                  row_new[w].counter = row_cur[w].counter - BPB_CNT_W'(1);
               end
            end else begin
               row_new[w].tag     = branch_addr;
               row_new[w].counter = BPB_CNT_W'(BPB_WEAK_STATE) + BPB_CNT_W'(taken);
            end
         end
      end
   end

   assign status.hit                = found;
   assign status.predicted_taken    = pred;
   assign status.prediction_correct = found && (pred == taken);

endmodule
